[sv/tpq_pkg.sv]
// Shared types, codes and constants of the tree path min/max query unit.
`default_nettype none
package tpq_pkg;

	localparam int NODE_W   = 11;
	localparam int WEIGHT_W = 20;
	localparam int MINW_W   = 30;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_LEVELS    = 11;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(2);
	localparam logic [MINW_W-1:0] NO_EDGE_MIN    = MINW_W'(987654321);

	// Item function codes.
	localparam logic [1:0] FN_EDGE  = 2'd0;
	localparam logic [1:0] FN_BUILD = 2'd1;
	localparam logic [1:0] FN_QUERY = 2'd2;
	localparam logic [1:0] FN_NOP   = 2'd3;

	// Register index taken from the word address.
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]          func;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [MINW_W-1:0]   min_weight;
		logic [WEIGHT_W-1:0] max_weight;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BCLR,
		ST_BINIT,
		ST_BPOS,
		ST_BEDGE,
		ST_BSEEN,
		ST_BPOP,
		ST_FS,
		ST_FT,
		ST_FW,
		ST_QLA,
		ST_QLB,
		ST_QSW,
		ST_QUP,
		ST_QUPD,
		ST_QCMP,
		ST_QRA,
		ST_QRB,
		ST_QLD,
		ST_QDONE
	} state_t;

endpackage
`default_nettype wire

[sv/tpq_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
`default_nettype none
module tpq_ram #(
	parameter int W = 1,
	parameter int D = 2,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/tree_path_min_max_query_unit.sv]
// Top level of the tree path min/max query unit: control sequencer and table memories.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_ready  | in_item  (func, node_a, node_b, weight)
//   out     | out | out_valid/out_ready| out_item (min_weight, max_weight)
//   cfg     | in  | psel/penable/pready| paddr, pwdata, prdata (node_count)
//
// Add-edge and no-op items are taken in the idle state. A query reads the depths of both
// nodes, lifts the deeper one with one ancestor-table read per step from the top lifting
// level down to even the depths, then climbs both nodes level by level. A build clears
// the table, walks the edges depth first, reading each edge end and popping each finished
// node, and fills the table per node and level. Reset leaves the tables reading as zero
// until the first build. A finished result waits in the output register while the next
// item is taken; a second result holds the input until it frees.
`default_nettype none
module tree_path_min_max_query_unit #(
	parameter int MAX_NODES = tpq_pkg::DEF_MAX_NODES,
	parameter int LEVELS    = tpq_pkg::DEF_LEVELS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire tpq_pkg::in_item_t           in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output tpq_pkg::out_item_t               out_item,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tpq_pkg::APB_AW-1:0]  paddr,
	input  wire logic [tpq_pkg::APB_DW-1:0]  pwdata,
	output logic      [tpq_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);

	localparam int FW     = tpq_pkg::NODE_W;
	localparam int WW     = tpq_pkg::WEIGHT_W;
	localparam int MW     = tpq_pkg::MINW_W;
	localparam int NW     = $clog2(MAX_NODES + 1);
	localparam int XW     = (NW > FW) ? NW : FW;
	localparam int LW     = NW;
	localparam int LVW    = $clog2(LEVELS);
	localparam int TDEPTH = (MAX_NODES + 1) * LEVELS;
	localparam int TW     = $clog2(TDEPTH);
	localparam int TEW    = NW + 2 * WW;
	localparam int EDEPTH = MAX_NODES - 1;
	localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
	localparam int EEW    = 2 * FW + WW;
	localparam int ETW    = $clog2(MAX_NODES);
	localparam int PW     = ETW + 1;
	localparam int NDEPTH = MAX_NODES + 1;
	localparam int SPW    = $clog2(MAX_NODES + 2);
	localparam int SEW    = NW + PW + LW;

	tpq_pkg::state_t state_q, state_d;

	logic [FW-1:0]     node_count_q;
	logic              built_q;
	logic [ETW-1:0]    edge_total_q;
	logic              out_valid_q;
	tpq_pkg::out_item_t out_item_q;

	logic [XW-1:0]  a_q, b_q;
	logic [LW-1:0]  la_q, lb_q;
	logic [LVW-1:0] i_q;
	logic           fin_q;
	logic [MW-1:0]  lo_q;
	logic [WW-1:0]  hi_q;
	logic [TEW-1:0] sa_q;
	logic [TW-1:0]  clr_q;
	logic [NW-1:0]  cur_q, nb_q, j_q;
	logic [PW-1:0]  pos_q;
	logic           par_q;
	logic [LW-1:0]  lvl_q;
	logic [SPW-1:0] sp_q;
	logic [WW-1:0]  w_q;

	logic [NW-1:0]  eff_n;
	logic [LVW-1:0] top_h;

	// Memory ports.
	logic           t_we, t_rd_en, t_ok_q;
	logic [TW-1:0]  t_waddr, t_raddr;
	logic [TEW-1:0] t_wdata, t_rdata, t_data;
	logic [XW-1:0]  t_rd_node;
	logic [LVW-1:0] t_rd_lvl;
	logic           n_we, n_rd_en, n_ok_q;
	logic [NW-1:0]  n_waddr, n_raddr;
	logic [LW-1:0]  n_wdata, n_rdata, n_data;
	logic [XW-1:0]  n_rd_node;
	logic           e_we;
	logic [EAW-1:0] e_waddr, e_raddr;
	logic [EEW-1:0] e_wdata, e_rdata;
	logic           s_we;
	logic [NW-1:0]  s_waddr, s_raddr;
	logic [SEW-1:0] s_wdata, s_rdata;

	logic in_fire, out_free, cfg_wr, scan_end, up_go, cand, skip;
	logic [FW-1:0]  ea, eb;
	logic [WW-1:0]  ew;
	logic [NW-1:0]  nb_c;
	logic [NW-1:0]  sa_up, sb_up;
	logic [WW-1:0]  sa_hi, sb_hi, sa_lo, sb_lo;
	logic [WW-1:0]  hi_pair;
	logic [WW-1:0]  lo_pair;
	logic [31:0]    n32;
	logic signed [31:0] dif;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == tpq_pkg::REG_NODE_COUNT) ? 32'(node_count_q) : '0;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Effective node count and top lifting level.
	always_comb begin
		n32 = 32'(node_count_q);
		if (n32 < 32'd2) begin
			n32 = 32'd2;
		end
		if (n32 > 32'(MAX_NODES)) begin
			n32 = 32'(MAX_NODES);
		end
		eff_n = NW'(n32);
	end

	always_comb begin
		top_h = '0;
		for (int k = 0; k < LEVELS - 1; k++) begin
			if ((32'd1 << k) < n32) begin
				top_h = top_h + LVW'(1);
			end
		end
	end

	assign t_data = t_ok_q ? t_rdata : '0;
	assign n_data = n_ok_q ? n_rdata : '0;

	assign ea = e_rdata[EEW-1 -: FW];
	assign eb = e_rdata[WW+FW-1 -: FW];
	assign ew = e_rdata[WW-1:0];

	always_comb begin
		cand = 1'b0;
		nb_c = '0;
		if (32'(ea) >= 32'd1 && 32'(ea) <= n32 && 32'(eb) >= 32'd1 && 32'(eb) <= n32) begin
			if (!par_q && 32'(ea) == 32'(cur_q)) begin
				cand = 1'b1;
				nb_c = NW'(eb);
			end else if (par_q && 32'(eb) == 32'(cur_q)) begin
				cand = 1'b1;
				nb_c = NW'(ea);
			end
		end
	end

	assign scan_end = pos_q >= {edge_total_q, 1'b0};
	assign dif      = $signed(32'(lb_q)) - $signed(32'(la_q));
	assign up_go    = dif >= $signed(32'd1 << i_q);

	assign sa_up = sa_q[TEW-1 -: NW];
	assign sa_hi = sa_q[2*WW-1 -: WW];
	assign sa_lo = sa_q[WW-1:0];
	assign sb_up = t_data[TEW-1 -: NW];
	assign sb_hi = t_data[2*WW-1 -: WW];
	assign sb_lo = t_data[WW-1:0];
	assign hi_pair = (sa_hi > sb_hi) ? sa_hi : sb_hi;
	assign lo_pair = (sa_lo < sb_lo) ? sa_lo : sb_lo;
	assign skip = (sa_up == sb_up) || (sa_up == '0) || (sb_up == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tpq_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_item.func == tpq_pkg::FN_BUILD) begin
						state_d = tpq_pkg::ST_BCLR;
					end else if (in_item.func == tpq_pkg::FN_QUERY) begin
						state_d = tpq_pkg::ST_QLA;
					end
				end
			end
			tpq_pkg::ST_BCLR: begin
				if (clr_q == TW'(TDEPTH - 1)) state_d = tpq_pkg::ST_BINIT;
			end
			tpq_pkg::ST_BINIT: state_d = tpq_pkg::ST_BPOS;
			tpq_pkg::ST_BPOS: begin
				if (!scan_end) begin
					state_d = tpq_pkg::ST_BEDGE;
				end else if (sp_q == SPW'(1)) begin
					state_d = tpq_pkg::ST_FS;
				end else begin
					state_d = tpq_pkg::ST_BPOP;
				end
			end
			tpq_pkg::ST_BEDGE: state_d = cand ? tpq_pkg::ST_BSEEN : tpq_pkg::ST_BPOS;
			tpq_pkg::ST_BSEEN: state_d = tpq_pkg::ST_BPOS;
			tpq_pkg::ST_BPOP:  state_d = tpq_pkg::ST_BPOS;
			tpq_pkg::ST_FS:    state_d = tpq_pkg::ST_FT;
			tpq_pkg::ST_FT:    state_d = tpq_pkg::ST_FW;
			tpq_pkg::ST_FW: begin
				state_d = (j_q == eff_n && i_q == top_h) ? tpq_pkg::ST_IDLE : tpq_pkg::ST_FS;
			end
			tpq_pkg::ST_QLA: state_d = tpq_pkg::ST_QLB;
			tpq_pkg::ST_QLB: state_d = tpq_pkg::ST_QSW;
			tpq_pkg::ST_QSW: state_d = tpq_pkg::ST_QUP;
			tpq_pkg::ST_QUP: begin
				if (up_go) begin
					state_d = tpq_pkg::ST_QUPD;
				end else if (i_q == '0) begin
					state_d = tpq_pkg::ST_QCMP;
				end
			end
			tpq_pkg::ST_QUPD: state_d = (i_q == '0) ? tpq_pkg::ST_QCMP : tpq_pkg::ST_QUP;
			tpq_pkg::ST_QCMP: state_d = (a_q != b_q) ? tpq_pkg::ST_QRA : tpq_pkg::ST_QDONE;
			tpq_pkg::ST_QRA:  state_d = tpq_pkg::ST_QRB;
			tpq_pkg::ST_QRB:  state_d = tpq_pkg::ST_QLD;
			tpq_pkg::ST_QLD:  state_d = fin_q ? tpq_pkg::ST_QDONE : tpq_pkg::ST_QRA;
			tpq_pkg::ST_QDONE: begin
				if (out_free) state_d = tpq_pkg::ST_IDLE;
			end
			default: state_d = tpq_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		in_ready  = 1'b0;
		t_we      = 1'b0;
		t_waddr   = '0;
		t_wdata   = '0;
		t_rd_en   = 1'b0;
		t_rd_node = '0;
		t_rd_lvl  = '0;
		n_we      = 1'b0;
		n_waddr   = '0;
		n_wdata   = '0;
		n_rd_en   = 1'b0;
		n_rd_node = '0;
		e_we      = 1'b0;
		e_waddr   = EAW'(edge_total_q);
		e_wdata   = {in_item.node_a, in_item.node_b, in_item.weight};
		e_raddr   = EAW'(pos_q >> 1);
		s_we      = 1'b0;
		s_waddr   = NW'(sp_q - SPW'(1));
		s_wdata   = {cur_q, pos_q, lvl_q};
		s_raddr   = NW'(sp_q - SPW'(2));
		case (state_q)
			tpq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				e_we = in_fire && in_item.func == tpq_pkg::FN_EDGE &&
					32'(edge_total_q) < 32'(MAX_NODES - 1);
			end
			tpq_pkg::ST_BCLR: begin
				t_we    = 1'b1;
				t_waddr = clr_q;
				n_we    = 32'(clr_q) < 32'(NDEPTH);
				n_waddr = NW'(clr_q);
			end
			tpq_pkg::ST_BINIT: begin
				n_we    = 1'b1;
				n_waddr = NW'(1);
				n_wdata = LW'(1);
			end
			tpq_pkg::ST_BEDGE: begin
				n_rd_en   = 1'b1;
				n_rd_node = XW'(nb_c);
			end
			tpq_pkg::ST_BSEEN: begin
				if (n_data == '0) begin
					t_we    = 1'b1;
					t_waddr = TW'(32'(nb_q) * 32'(LEVELS));
					t_wdata = {cur_q, w_q, w_q};
					n_we    = 1'b1;
					n_waddr = nb_q;
					n_wdata = lvl_q + LW'(1);
					s_we    = sp_q <= SPW'(MAX_NODES);
				end
			end
			tpq_pkg::ST_FS: begin
				t_rd_en   = 1'b1;
				t_rd_node = XW'(j_q);
				t_rd_lvl  = i_q - LVW'(1);
			end
			tpq_pkg::ST_FT: begin
				t_rd_en   = 1'b1;
				t_rd_node = XW'(t_data[TEW-1 -: NW]);
				t_rd_lvl  = i_q - LVW'(1);
			end
			tpq_pkg::ST_FW: begin
				if (sb_up != '0) begin
					t_we    = 1'b1;
					t_waddr = TW'(32'(j_q) * 32'(LEVELS) + 32'(i_q));
					t_wdata = {sb_up, hi_pair, lo_pair};
				end
			end
			tpq_pkg::ST_QLA: begin
				n_rd_en   = 1'b1;
				n_rd_node = a_q;
			end
			tpq_pkg::ST_QLB: begin
				n_rd_en   = 1'b1;
				n_rd_node = b_q;
			end
			tpq_pkg::ST_QUP: begin
				t_rd_en   = 1'b1;
				t_rd_node = b_q;
				t_rd_lvl  = i_q;
			end
			tpq_pkg::ST_QRA: begin
				t_rd_en   = 1'b1;
				t_rd_node = a_q;
				t_rd_lvl  = i_q;
			end
			tpq_pkg::ST_QRB: begin
				t_rd_en   = 1'b1;
				t_rd_node = b_q;
				t_rd_lvl  = i_q;
			end
			default: begin
			end
		endcase
	end

	assign t_raddr = TW'(32'(NW'(t_rd_node)) * 32'(LEVELS) + 32'(t_rd_lvl));
	assign n_raddr = NW'(n_rd_node);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tpq_pkg::ST_IDLE;
			node_count_q <= tpq_pkg::NODE_COUNT_RST;
			built_q      <= 1'b0;
			edge_total_q <= '0;
			out_valid_q  <= 1'b0;
			t_ok_q       <= 1'b0;
			n_ok_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == tpq_pkg::REG_NODE_COUNT) begin
				node_count_q <= pwdata[FW-1:0];
			end
			if (e_we) begin
				edge_total_q <= edge_total_q + ETW'(1);
			end
			if (in_fire && in_item.func == tpq_pkg::FN_BUILD) begin
				built_q <= 1'b1;
			end
			if (state_q == tpq_pkg::ST_QDONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// A node beyond the table, or any node before the first build, reads as zero.
			t_ok_q <= t_rd_en && built_q && t_rd_node <= XW'(MAX_NODES);
			n_ok_q <= n_rd_en && built_q && n_rd_node <= XW'(MAX_NODES);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			tpq_pkg::ST_IDLE: begin
				a_q   <= XW'(in_item.node_a);
				b_q   <= XW'(in_item.node_b);
				lo_q  <= tpq_pkg::NO_EDGE_MIN;
				hi_q  <= '0;
				clr_q <= '0;
			end
			tpq_pkg::ST_BCLR: clr_q <= clr_q + TW'(1);
			tpq_pkg::ST_BINIT: begin
				cur_q <= NW'(1);
				pos_q <= '0;
				lvl_q <= LW'(1);
				sp_q  <= SPW'(1);
			end
			tpq_pkg::ST_BPOS: begin
				if (!scan_end) begin
					pos_q <= pos_q + PW'(1);
					par_q <= pos_q[0];
				end else if (sp_q == SPW'(1)) begin
					j_q <= NW'(1);
					i_q <= LVW'(1);
				end else begin
					sp_q <= sp_q - SPW'(1);
				end
			end
			tpq_pkg::ST_BEDGE: begin
				nb_q <= nb_c;
				w_q  <= ew;
			end
			tpq_pkg::ST_BSEEN: begin
				// Past the stack depth a newly reached node is recorded but not descended into.
				if (n_data == '0 && sp_q <= SPW'(MAX_NODES)) begin
					cur_q <= nb_q;
					pos_q <= '0;
					lvl_q <= lvl_q + LW'(1);
					sp_q  <= sp_q + SPW'(1);
				end
			end
			tpq_pkg::ST_BPOP: {cur_q, pos_q, lvl_q} <= s_rdata;
			tpq_pkg::ST_FT: sa_q <= t_data;
			tpq_pkg::ST_FW: begin
				if (j_q == eff_n) begin
					j_q <= NW'(1);
					i_q <= i_q + LVW'(1);
				end else begin
					j_q <= j_q + NW'(1);
				end
			end
			tpq_pkg::ST_QLB: la_q <= n_data;
			tpq_pkg::ST_QSW: begin
				if (la_q > n_data) begin
					a_q  <= b_q;
					b_q  <= a_q;
					la_q <= n_data;
					lb_q <= la_q;
				end else begin
					lb_q <= n_data;
				end
				i_q <= top_h;
			end
			tpq_pkg::ST_QUP: begin
				if (!up_go && i_q != '0) i_q <= i_q - LVW'(1);
			end
			tpq_pkg::ST_QUPD: begin
				if (MW'(sb_lo) < lo_q) lo_q <= MW'(sb_lo);
				if (sb_hi > hi_q) hi_q <= sb_hi;
				b_q  <= XW'(sb_up);
				// A missing ancestor is node zero, whose depth is zero.
				lb_q <= (sb_up == '0) ? '0 : LW'(32'(lb_q) - (32'd1 << i_q));
				if (i_q != '0) i_q <= i_q - LVW'(1);
			end
			tpq_pkg::ST_QCMP: begin
				i_q   <= top_h;
				fin_q <= 1'b0;
			end
			tpq_pkg::ST_QRB: sa_q <= t_data;
			tpq_pkg::ST_QLD: begin
				if (fin_q || !skip) begin
					if (MW'(lo_pair) < lo_q) lo_q <= MW'(lo_pair);
					if (hi_pair > hi_q) hi_q <= hi_pair;
				end
				if (!fin_q) begin
					if (!skip) begin
						a_q <= XW'(sa_up);
						b_q <= XW'(sb_up);
					end
					if (i_q == '0) begin
						fin_q <= 1'b1;
					end else begin
						i_q <= i_q - LVW'(1);
					end
				end
			end
			tpq_pkg::ST_QDONE: begin
				if (out_free) begin
					out_item_q.min_weight <= lo_q;
					out_item_q.max_weight <= hi_q;
				end
			end
			default: begin
			end
		endcase
	end

	tpq_ram #(.W(TEW), .D(TDEPTH)) u_anc_ram (
		.clk  (clk),
		.we   (t_we),
		.waddr(t_waddr),
		.wdata(t_wdata),
		.raddr(t_raddr),
		.rdata(t_rdata)
	);

	tpq_ram #(.W(LW), .D(NDEPTH)) u_lvl_ram (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(n_wdata),
		.raddr(n_raddr),
		.rdata(n_rdata)
	);

	tpq_ram #(.W(EEW), .D(EDEPTH)) u_edge_ram (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	tpq_ram #(.W(SEW), .D(NDEPTH)) u_stack_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

endmodule
`default_nettype wire

[tb/sv/tree_path_min_max_query_unit_test.sv]
// Self-checking testbench of the tree path min/max query unit.
`timescale 1ns / 100ps
module tree_path_min_max_query_unit_test;

	localparam int MAXN = tpq_pkg::DEF_MAX_NODES;
	localparam int LVLS = tpq_pkg::DEF_LEVELS;
	localparam int NW_T = tpq_pkg::NODE_W;
	localparam int WW_T = tpq_pkg::WEIGHT_W;
	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tpq_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	tpq_pkg::out_item_t out_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [tpq_pkg::APB_AW-1:0] paddr = '0;
	logic [tpq_pkg::APB_DW-1:0] pwdata = '0;
	logic [tpq_pkg::APB_DW-1:0] prdata;
	logic pready;

	tree_path_min_max_query_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the block's state.
	bit [NW_T-1:0]     edge_a [0:MAXN-2];
	bit [NW_T-1:0]     edge_b [0:MAXN-2];
	bit [WW_T-1:0]     edge_w [0:MAXN-2];
	int unsigned       edges_loaded;
	bit [NW_T-1:0]     anc_up [0:MAXN][0:LVLS-1];
	bit [WW_T-1:0]     anc_hi [0:MAXN][0:LVLS-1];
	bit [WW_T-1:0]     anc_lo [0:MAXN][0:LVLS-1];
	int                depth  [0:MAXN];
	bit                visited[0:MAXN];
	bit [NW_T-1:0]     node_count_reg;
	int unsigned       dfs_node[0:MAXN];
	int unsigned       dfs_pos [0:MAXN];

	tpq_pkg::out_item_t path_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_req = 0;
	int hold_cnt = 0;

	function automatic int nodes_eff();
		int n;
		n = node_count_reg;
		if (n < 2) n = 2;
		if (n > MAXN) n = MAXN;
		return n;
	endfunction

	function automatic int top_lvl();
		int h;
		h = 0;
		while (h < LVLS - 1 && (1 << h) < nodes_eff()) h++;
		return h;
	endfunction

	function automatic int lvl_of(int unsigned v);
		return (v > MAXN) ? 0 : depth[v];
	endfunction

	function automatic void clear_tables();
		for (int v = 0; v <= MAXN; v++) begin
			depth[v] = 0;
			visited[v] = 1'b0;
			for (int i = 0; i < LVLS; i++) begin
				anc_up[v][i] = '0;
				anc_hi[v][i] = '0;
				anc_lo[v][i] = '0;
			end
		end
	endfunction

	function automatic void build_tables();
		int n, h;
		int unsigned sp, cur, pos, e, nb, s_up;
		n = nodes_eff();
		h = top_lvl();
		clear_tables();
		depth[1] = 1;
		visited[1] = 1'b1;
		dfs_node[0] = 1;
		dfs_pos[0] = 0;
		sp = 1;
		while (sp > 0) begin
			cur = dfs_node[sp-1];
			pos = dfs_pos[sp-1];
			nb = 0;
			if (pos >= 2 * edges_loaded) begin
				sp--;
				continue;
			end
			dfs_pos[sp-1] = pos + 1;
			e = pos >> 1;
			if (edge_a[e] < 1 || edge_a[e] > n || edge_b[e] < 1 || edge_b[e] > n) continue;
			if (pos[0] == 1'b0) begin
				if (edge_a[e] == cur) nb = edge_b[e];
			end else begin
				if (edge_b[e] == cur) nb = edge_a[e];
			end
			if (nb == 0 || visited[nb]) continue;
			anc_up[nb][0] = cur;
			anc_hi[nb][0] = edge_w[e];
			anc_lo[nb][0] = edge_w[e];
			depth[nb] = depth[cur] + 1;
			visited[nb] = 1'b1;
			if (sp <= MAXN) begin
				dfs_node[sp] = nb;
				dfs_pos[sp] = 0;
				sp++;
			end
		end
		for (int i = 1; i <= h; i++) begin
			for (int j = 1; j <= n; j++) begin
				s_up = anc_up[j][i-1];
				if (anc_up[s_up][i-1] != 0) begin
					anc_up[j][i] = anc_up[s_up][i-1];
					anc_hi[j][i] = (anc_hi[j][i-1] > anc_hi[s_up][i-1]) ?
						anc_hi[j][i-1] : anc_hi[s_up][i-1];
					anc_lo[j][i] = (anc_lo[j][i-1] < anc_lo[s_up][i-1]) ?
						anc_lo[j][i-1] : anc_lo[s_up][i-1];
				end
			end
		end
	endfunction

	// Path extremes; nodes above MAXN read as all-zero entries.
	function automatic tpq_pkg::out_item_t path_extremes(int unsigned a, int unsigned b);
		int h;
		int unsigned t, lo, hi, ua, ub;
		tpq_pkg::out_item_t r;
		h = top_lvl();
		lo = tpq_pkg::NO_EDGE_MIN;
		hi = 0;
		if (lvl_of(a) > lvl_of(b)) begin
			t = a; a = b; b = t;
		end
		if (lvl_of(a) != lvl_of(b)) begin
			for (int i = h; i >= 0; i--) begin
				if (lvl_of(b) - lvl_of(a) >= (1 << i)) begin
					if (b <= MAXN) begin
						if (anc_lo[b][i] < lo) lo = anc_lo[b][i];
						if (anc_hi[b][i] > hi) hi = anc_hi[b][i];
						b = anc_up[b][i];
					end else begin
						lo = 0;
						b = 0;
					end
				end
				if (lvl_of(a) == lvl_of(b)) break;
			end
		end
		if (a != b) begin
			for (int i = h; i >= 0; i--) begin
				ua = (a <= MAXN) ? anc_up[a][i] : 0;
				ub = (b <= MAXN) ? anc_up[b][i] : 0;
				if (ua == ub || ua == 0 || ub == 0) continue;
				if (anc_hi[a][i] > hi) hi = anc_hi[a][i];
				if (anc_hi[b][i] > hi) hi = anc_hi[b][i];
				if (anc_lo[a][i] < lo) lo = anc_lo[a][i];
				if (anc_lo[b][i] < lo) lo = anc_lo[b][i];
				a = ua;
				b = ub;
			end
			if (a <= MAXN) begin
				if (anc_hi[a][0] > hi) hi = anc_hi[a][0];
				if (anc_lo[a][0] < lo) lo = anc_lo[a][0];
			end else lo = 0;
			if (b <= MAXN) begin
				if (anc_hi[b][0] > hi) hi = anc_hi[b][0];
				if (anc_lo[b][0] < lo) lo = anc_lo[b][0];
			end else lo = 0;
		end
		r.min_weight = lo[tpq_pkg::MINW_W-1:0];
		r.max_weight = hi[WW_T-1:0];
		return r;
	endfunction

	function automatic void absorb_item(tpq_pkg::in_item_t it);
		if (it.func == tpq_pkg::FN_EDGE) begin
			if (edges_loaded < MAXN - 1) begin
				edge_a[edges_loaded] = it.node_a;
				edge_b[edges_loaded] = it.node_b;
				edge_w[edges_loaded] = it.weight;
				edges_loaded++;
			end
		end else if (it.func == tpq_pkg::FN_BUILD) begin
			build_tables();
		end else if (it.func == tpq_pkg::FN_QUERY) begin
			path_results.insert(path_results.size(), path_extremes(it.node_a, it.node_b));
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random stalls plus requested long hold-offs.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Outputs only change at rising edges, so the falling edge sees stable values.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (path_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", out_item);
			end else begin
				if (out_item.min_weight !== path_results[0].min_weight ||
				    out_item.max_weight !== path_results[0].max_weight) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: min %0d/%0d max %0d/%0d (expected/actual)",
							path_results[0].min_weight, out_item.min_weight,
							path_results[0].max_weight, out_item.max_weight);
				end
				void'(path_results.pop_front());
			end
		end
	end

	task automatic send_item(logic [1:0] fn, int unsigned a, int unsigned b, int unsigned w);
		tpq_pkg::in_item_t it;
		bit ok;
		it.func = fn;
		it.node_a = a[NW_T-1:0];
		it.node_b = b[NW_T-1:0];
		it.weight = w[WW_T-1:0];
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end
		absorb_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (path_results.size() != 0) @(posedge clk);
		// A query is the last item of each phase, so this covers its tail.
		repeat (100) @(posedge clk);
	endtask

	task automatic write_node_count(int unsigned v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		node_count_reg = v[NW_T-1:0];
	endtask

	task automatic test_directed();
		send_item(tpq_pkg::FN_QUERY, 1, 2, 0);
		send_item(tpq_pkg::FN_QUERY, 1, 1, 0);
		send_item(tpq_pkg::FN_NOP, 2047, 2047, 20'hFFFFF);
		send_item(tpq_pkg::FN_EDGE, 1, 2, 20'hFFFFF);
		send_item(tpq_pkg::FN_EDGE, 0, 2047, 1);
		send_item(tpq_pkg::FN_EDGE, 2, 1024, 0);
		send_item(tpq_pkg::FN_BUILD, 0, 0, 0);
		send_item(tpq_pkg::FN_QUERY, 1, 2, 0);
		send_item(tpq_pkg::FN_QUERY, 2, 1, 0);
		send_item(tpq_pkg::FN_QUERY, 2, 2, 0);
		send_item(tpq_pkg::FN_QUERY, 0, 1, 0);
		send_item(tpq_pkg::FN_QUERY, 2047, 2047, 0);
		send_item(tpq_pkg::FN_QUERY, 1024, 1, 0);
		send_item(tpq_pkg::FN_QUERY, 3, 1, 0);
		drain();
		write_node_count(0);
		send_item(tpq_pkg::FN_QUERY, 2, 1, 0);
		drain();
		write_node_count(2047);
		send_item(tpq_pkg::FN_BUILD, 0, 0, 0);
		send_item(tpq_pkg::FN_QUERY, 1, 2, 0);
		send_item(tpq_pkg::FN_QUERY, 1, 1024, 0);
		send_item(tpq_pkg::FN_QUERY, 1024, 2047, 0);
		drain();
	endtask

	// Random tree with some noise edges, one build, then mostly queries.
	task automatic test_tree_phase(int unsigned n, int nq);
		int unsigned a, b, p;
		write_node_count(n);
		for (int v = 2; v <= n; v++) begin
			if (edges_loaded >= MAXN - 1 && $urandom_range(9) != 0) break;
			p = $urandom_range(v - 1, 1);
			if ($urandom_range(1)) send_item(tpq_pkg::FN_EDGE, v, p, $urandom);
			else send_item(tpq_pkg::FN_EDGE, p, v, $urandom);
			if ($urandom_range(19) == 0)
				send_item(tpq_pkg::FN_EDGE, $urandom_range(2047), $urandom, $urandom);
		end
		send_item(tpq_pkg::FN_BUILD, $urandom, $urandom, $urandom);
		for (int k = 0; k < nq; k++) begin
			a = $urandom_range(n, 1);
			b = $urandom_range(n, 1);
			case ($urandom_range(19))
				0: a = $urandom_range(2047);
				1: b = $urandom_range(2047, 1024);
				2: b = a;
				default: ;
			endcase
			if ($urandom_range(24) == 0) send_item(tpq_pkg::FN_NOP, a, b, $urandom);
			else send_item(tpq_pkg::FN_QUERY, a, b, $urandom);
		end
		send_item(tpq_pkg::FN_QUERY, $urandom_range(n, 1), 1, 0);
		drain();
	endtask

	// The receiver stops long enough for the block to stall its input.
	task automatic test_backpressure();
		hold_req = 3000;
		for (int k = 0; k < 40; k++)
			send_item(tpq_pkg::FN_QUERY, $urandom_range(nodes_eff(), 1),
				$urandom_range(nodes_eff(), 1), 0);
		drain();
	endtask

	initial begin
		edges_loaded = 0;
		node_count_reg = tpq_pkg::NODE_COUNT_RST;
		clear_tables();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 15;
		recv_idle = 69;
		test_directed();
		test_tree_phase(5, 60);
		test_tree_phase(30, 120);
		send_idle = 69;
		recv_idle = 15;
		test_tree_phase(64, 120);
		test_tree_phase($urandom_range(150, 90), 120);
		test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		test_tree_phase($urandom_range(300, 160), 120);
		test_tree_phase(1024, 200);
		test_backpressure();
		drain();
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
